[rtl/assert_macros.svh]
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define CRAST_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that also checks behavior out of reset.
`define CRAST_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

[rtl/crast_pkg.sv]
// Package: constants and types shared by the circle rasterizer modules.
`default_nettype none

package crast_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAX_RADIUS = 31;
    localparam int RUN_CAP    = 64;
    localparam int RAD_BITS   = 5;
    localparam int COLOUR_BITS = 16;
    localparam int X_BITS     = 7;   // -MAX_RADIUS .. +1
    localparam int Y_BITS     = 8;   // 0 .. RUN_CAP, signed for compares
    localparam int ERR_BITS   = 16;
    localparam int CNT_BITS   = 7;   // 0 .. RUN_CAP

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Sequencer commands to the stepper.
    typedef struct packed {
        logic load;
        logic advance;
    } t_step_ctl;

    // Current step position and end-of-walk flag for the step being taken.
    typedef struct packed {
        logic signed [X_BITS-1:0] x;
        logic signed [Y_BITS-1:0] y;
        logic                     last;
    } t_step_stat;

endpackage

`default_nettype wire

[rtl/crast_step.sv]
// Error-term circle stepper: holds step x, y, error and run count.
`default_nettype none

module crast_step (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire crast_pkg::t_step_ctl          i_ctl,
    input  wire logic [crast_pkg::RAD_BITS-1:0] i_radius,
    output crast_pkg::t_step_stat              o_stat
);

    logic signed [crast_pkg::X_BITS-1:0]   r_x, n_x;
    logic signed [crast_pkg::Y_BITS-1:0]   r_y, n_y;
    logic signed [crast_pkg::ERR_BITS-1:0] r_err, n_err;
    logic        [crast_pkg::CNT_BITS-1:0] r_cnt, n_cnt;

    logic        [crast_pkg::RAD_BITS-1:0] w_rad;
    logic signed [crast_pkg::ERR_BITS-1:0] w_x_ext, w_y_ext, w_y1_ext, w_x1_ext;
    logic signed [crast_pkg::ERR_BITS-1:0] w_e2, w_err1, w_err2;
    logic signed [crast_pkg::X_BITS-1:0]   w_x1;
    logic signed [crast_pkg::Y_BITS-1:0]   w_y1;
    logic        [crast_pkg::CNT_BITS-1:0] w_cnt1;
    logic                                  w_last;

    // Saturate the radius.
    assign w_rad = (i_radius > crast_pkg::RAD_BITS'(crast_pkg::MAX_RADIUS)) ?
                   crast_pkg::RAD_BITS'(crast_pkg::MAX_RADIUS) : i_radius;

    assign w_x_ext = crast_pkg::ERR_BITS'(r_x);
    assign w_y_ext = crast_pkg::ERR_BITS'(r_y);

    always_comb begin
        w_e2   = r_err;
        w_y1   = r_y;
        w_err1 = r_err;
        w_y1_ext = w_y_ext;
        if (r_err <= w_y_ext) begin
            w_y1     = r_y + crast_pkg::Y_BITS'(1);
            w_y1_ext = crast_pkg::ERR_BITS'(w_y1);
            w_err1   = r_err + (w_y1_ext <<< 1) + crast_pkg::ERR_BITS'(1);
            // Diagonal point: force the x move decision.
            if ((-w_x_ext == w_y1_ext) && (r_err <= w_x_ext)) begin
                w_e2 = '0;
            end
        end
        w_x1     = r_x;
        w_err2   = w_err1;
        w_x1_ext = w_x_ext;
        if (w_e2 > w_x_ext) begin
            w_x1     = r_x + crast_pkg::X_BITS'(1);
            w_x1_ext = crast_pkg::ERR_BITS'(w_x1);
            w_err2   = w_err1 + (w_x1_ext <<< 1) + crast_pkg::ERR_BITS'(1);
        end
    end

    assign w_cnt1 = r_cnt + crast_pkg::CNT_BITS'(1);
    assign w_last = (w_x1 > crast_pkg::X_BITS'(0)) ||
                    (w_cnt1 >= crast_pkg::CNT_BITS'(crast_pkg::RUN_CAP));

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_err = r_err;
        n_cnt = r_cnt;
        priority if (i_ctl.load) begin
            n_x   = -crast_pkg::X_BITS'(w_rad);
            n_y   = '0;
            n_err = crast_pkg::ERR_BITS'(2) +
                    crast_pkg::ERR_BITS'((crast_pkg::RAD_BITS'(w_rad) + 6'd1) >> 1);
            n_cnt = '0;
        end else if (i_ctl.advance) begin
            n_x   = w_x1;
            n_y   = w_y1;
            n_err = w_err2;
            n_cnt = w_cnt1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= '0;
            r_y   <= '0;
            r_err <= '0;
            r_cnt <= '0;
        end else begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_err <= n_err;
            r_cnt <= n_cnt;
        end
    end

    assign o_stat.x    = r_x;
    assign o_stat.y    = r_y;
    assign o_stat.last = w_last;

endmodule

`default_nettype wire

[rtl/circle_rasterizer_top.sv]
// Top level of the circle rasterizer: command intake, sequencer, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one circle command per beat:
//   centre, radius (saturated to 31) and colour.
//   Output channel (o_out_valid / i_out_ready) gives one beat per step of the
//   error-term walk: four mirrored pixel positions, the colour, and o_last on
//   the final beat of the circle. A circle yields at most 64 beats; the 64th
//   is forced last. Coordinates wrap modulo 2^16.
// Sequencing:
//   After a command is accepted the sequencer enters its run state and loads
//   the stepper; each step is then registered in the output register. The
//   stepper produces one result per cycle while the receiver keeps ready
//   high. No command is taken until the walk ends; the single stepper walks
//   one circle at a time.
//   The next command is taken while the last result still waits in the
//   output register.
// Reset: synchronous, active low; the block returns idle, ready for a command,
//   with no result pending.
// Stall: while i_out_ready is low the result register holds its beat and the
//   walk pauses; nothing is dropped.
`default_nettype none

module circle_rasterizer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_centre_x,
    input  wire logic [15:0] i_centre_y,
    input  wire logic [4:0]  i_radius,
    input  wire logic [15:0] i_colour,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_left_top_x,
    output logic [15:0]      o_left_top_y,
    output logic [15:0]      o_left_bottom_x,
    output logic [15:0]      o_left_bottom_y,
    output logic [15:0]      o_right_top_x,
    output logic [15:0]      o_right_top_y,
    output logic [15:0]      o_right_bottom_x,
    output logic [15:0]      o_right_bottom_y,
    output logic [15:0]      o_pixel_colour,
    output logic             o_last
);

    localparam int CB = crast_pkg::COORD_BITS;

    crast_pkg::t_state     r_state, n_state;
    crast_pkg::t_step_ctl  w_ctl;
    crast_pkg::t_step_stat w_stat;

    logic                                r_out_valid, n_out_valid;
    logic [CB-1:0]                       r_cx, r_cy;
    logic [crast_pkg::COLOUR_BITS-1:0]   r_colour;
    logic [CB-1:0]                       r_ltx, r_lty, r_lbx, r_lby;
    logic [CB-1:0]                       r_rtx, r_rty, r_rbx, r_rby;
    logic [crast_pkg::COLOUR_BITS-1:0]   r_pcol;
    logic                                r_last;

    logic          w_in_acc;
    logic          w_slot_free;
    logic          w_emit;
    logic [CB-1:0] w_dx, w_dy;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_emit      = (r_state == crast_pkg::ST_RUN) && w_slot_free;

    crast_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_radius (i_radius),
        .o_stat   (w_stat)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crast_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = crast_pkg::ST_RUN;
                end
            end
            crast_pkg::ST_RUN: begin
                if (w_emit && w_stat.last) begin
                    n_state = crast_pkg::ST_IDLE;
                end
            end
            default: n_state = crast_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_ready    = 1'b0;
        w_ctl.load    = 1'b0;
        w_ctl.advance = 1'b0;
        unique case (r_state)
            crast_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                w_ctl.load = i_in_valid;
            end
            crast_pkg::ST_RUN: begin
                w_ctl.advance = w_emit;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Hold the output beat until taken; load a new one when the slot frees.
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crast_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the command.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cx     <= i_centre_x;
            r_cy     <= i_centre_y;
            r_colour <= i_colour;
        end
    end

    // Step offsets, sign extended to coordinate width.
    assign w_dx = CB'(w_stat.x);
    assign w_dy = CB'(w_stat.y);

    // Mirror the step about the centre; coordinates wrap.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ltx  <= r_cx - w_dx;
            r_lty  <= r_cy - w_dy;
            r_lbx  <= r_cx - w_dx;
            r_lby  <= r_cy + w_dy;
            r_rtx  <= r_cx + w_dx;
            r_rty  <= r_cy - w_dy;
            r_rbx  <= r_cx + w_dx;
            r_rby  <= r_cy + w_dy;
            r_pcol <= r_colour;
            r_last <= w_stat.last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_top_x     = r_ltx;
    assign o_left_top_y     = r_lty;
    assign o_left_bottom_x  = r_lbx;
    assign o_left_bottom_y  = r_lby;
    assign o_right_top_x    = r_rtx;
    assign o_right_top_y    = r_rty;
    assign o_right_bottom_x = r_rbx;
    assign o_right_bottom_y = r_rby;
    assign o_pixel_colour   = r_pcol;
    assign o_last           = r_last;

endmodule

`default_nettype wire

[rtl/crast_checker.sv]
// Port-level checker for the circle rasterizer, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module crast_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_left_top_x,
    input wire logic [15:0] o_left_top_y,
    input wire logic [15:0] o_left_bottom_x,
    input wire logic [15:0] o_left_bottom_y,
    input wire logic [15:0] o_right_top_x,
    input wire logic [15:0] o_right_top_y,
    input wire logic [15:0] o_right_bottom_x,
    input wire logic [15:0] o_right_bottom_y,
    input wire logic        o_last
);

    // Out of reset: idle and nothing pending.
    `CRAST_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (o_in_ready && !o_out_valid))

    // A command keeps the block busy for at least the next cycle.
    `CRAST_ASSERT(a_busy_after_cmd, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready)

    // Pixel positions are mirror images of one step.
    `CRAST_ASSERT(a_mirror, i_clk, i_rst_n, o_out_valid |-> ((o_left_top_x == o_left_bottom_x) && (o_right_top_x == o_right_bottom_x) && (o_left_top_y == o_right_top_y) && (o_left_bottom_y == o_right_bottom_y)))

    // A stalled beat holds.
    `CRAST_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_left_top_x) && $stable(o_last)))

endmodule

bind circle_rasterizer_top crast_checker u_crast_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_left_top_x     (o_left_top_x),
    .o_left_top_y     (o_left_top_y),
    .o_left_bottom_x  (o_left_bottom_x),
    .o_left_bottom_y  (o_left_bottom_y),
    .o_right_top_x    (o_right_top_x),
    .o_right_top_y    (o_right_top_y),
    .o_right_bottom_x (o_right_bottom_x),
    .o_right_bottom_y (o_right_bottom_y),
    .o_last           (o_last)
);

`default_nettype wire

[test/circle_rasterizer_top_test.sv]
// Testbench for circle_rasterizer_top: table-driven and random circle commands checked beat by beat.
`default_nettype none

module circle_rasterizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // One circle command as it crosses the input channel.
    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [4:0]  radius;
        logic [15:0] colour;
    } t_circle_cmd;

    // One output beat: four mirrored pixels, their colour and the end-of-circle flag.
    typedef struct packed {
        logic [15:0] lt_x;
        logic [15:0] lt_y;
        logic [15:0] lb_x;
        logic [15:0] lb_y;
        logic [15:0] rt_x;
        logic [15:0] rt_y;
        logic [15:0] rb_x;
        logic [15:0] rb_y;
        logic [15:0] colour;
        logic        last;
    } t_pixel_beat;

    // Directed row: a command, plus a typed beat where the answer is obvious.
    typedef struct packed {
        t_circle_cmd cmd;
        logic        typed;
        t_pixel_beat beat;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 16;
    localparam int RANDOM_ITEMS  = 254;
    localparam int BURST_LEN     = 32;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_centre_x = '0;
    logic [15:0] i_centre_y = '0;
    logic [4:0]  i_radius = '0;
    logic [15:0] i_colour = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_left_top_x;
    logic [15:0] o_left_top_y;
    logic [15:0] o_left_bottom_x;
    logic [15:0] o_left_bottom_y;
    logic [15:0] o_right_top_x;
    logic [15:0] o_right_top_y;
    logic [15:0] o_right_bottom_x;
    logic [15:0] o_right_bottom_y;
    logic [15:0] o_pixel_colour;
    logic        o_last;

    // Beats still owed by the block, oldest first.
    t_pixel_beat pending_pixels [$];

    int mismatches    = 0;
    int circles_sent  = 0;
    int beats_seen    = 0;
    int longest_walk  = 0;
    int capped_walks  = 0;
    int stall_cycles  = 0;
    int drains        = 0;

    // Zero-radius rows collapse to one beat at the centre; everything else
    // goes through the walk predictor.
    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        '{'{16'h0000, 16'h0000, 5'd0, 16'h0000}, 1'b1,
          '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
            16'h0000, 16'h0000, 16'h0000, 1'b1}},
        '{'{16'hFFFF, 16'hFFFF, 5'd0, 16'hFFFF}, 1'b1,
          '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}},
        '{'{16'h1234, 16'h5678, 5'd0, 16'hA5A5}, 1'b1,
          '{16'h1234, 16'h5678, 16'h1234, 16'h5678, 16'h1234, 16'h5678,
            16'h1234, 16'h5678, 16'hA5A5, 1'b1}},
        '{'{16'h0064, 16'h0064, 5'd1,  16'h0001}, 1'b0, '0},
        '{'{16'h0064, 16'h0064, 5'd2,  16'h0002}, 1'b0, '0},
        '{'{16'h0064, 16'h0064, 5'd3,  16'h0004}, 1'b0, '0},
        '{'{16'h0000, 16'h0000, 5'd31, 16'h0000}, 1'b0, '0},
        '{'{16'hFFFF, 16'hFFFF, 5'd31, 16'hFFFF}, 1'b0, '0},
        '{'{16'hFFF0, 16'h000F, 5'd31, 16'h8000}, 1'b0, '0},
        '{'{16'h8000, 16'h8000, 5'd31, 16'h5A5A}, 1'b0, '0},
        '{'{16'h0000, 16'hFFFF, 5'd15, 16'h7FFF}, 1'b0, '0},
        '{'{16'h7FFF, 16'h0001, 5'd16, 16'h00FF}, 1'b0, '0},
        '{'{16'h4000, 16'hC000, 5'd30, 16'hFF00}, 1'b0, '0},
        '{'{16'hFFE5, 16'h001B, 5'd7,  16'hF0F0}, 1'b0, '0},
        '{'{16'h0003, 16'hFFFC, 5'd4,  16'h0F0F}, 1'b0, '0},
        '{'{16'hAAAA, 16'h5555, 5'd21, 16'hC3C3}, 1'b0, '0}
    };

    circle_rasterizer_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_centre_x      (i_centre_x),
        .i_centre_y      (i_centre_y),
        .i_radius        (i_radius),
        .i_colour        (i_colour),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_left_top_x    (o_left_top_x),
        .o_left_top_y    (o_left_top_y),
        .o_left_bottom_x (o_left_bottom_x),
        .o_left_bottom_y (o_left_bottom_y),
        .o_right_top_x   (o_right_top_x),
        .o_right_top_y   (o_right_top_y),
        .o_right_bottom_x(o_right_bottom_x),
        .o_right_bottom_y(o_right_bottom_y),
        .o_pixel_colour  (o_pixel_colour),
        .o_last          (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Walk the error-term stepper for one circle and queue every beat it yields.
    // Step state starts at x = -r, y = 0 with the shift-form error 2 + ceil(r/2);
    // the walk stops once x goes positive or the beat cap is reached.
    function automatic void trace_circle(input t_circle_cmd cmd);
        int          sx;
        int          sy;
        int          err;
        int          e2;
        int          rad;
        int          beats;
        bit          done;
        t_pixel_beat b;
        rad = int'(cmd.radius);
        if (rad > crast_pkg::MAX_RADIUS) begin
            rad = crast_pkg::MAX_RADIUS;
        end
        sx    = -rad;
        sy    = 0;
        err   = 2 + ((rad + 1) >>> 1);
        beats = 0;
        done  = 1'b0;
        while (!done) begin
            b.lt_x   = 16'(int'(cmd.cx) - sx);
            b.lt_y   = 16'(int'(cmd.cy) - sy);
            b.lb_x   = 16'(int'(cmd.cx) - sx);
            b.lb_y   = 16'(int'(cmd.cy) + sy);
            b.rt_x   = 16'(int'(cmd.cx) + sx);
            b.rt_y   = 16'(int'(cmd.cy) - sy);
            b.rb_x   = 16'(int'(cmd.cx) + sx);
            b.rb_y   = 16'(int'(cmd.cy) + sy);
            b.colour = cmd.colour;
            beats++;
            e2 = err;
            if (e2 <= sy) begin
                sy++;
                err += sy * 2 + 1;
                // diagonal corner: force the x step as well
                if (-sx == sy && e2 <= sx) begin
                    e2 = 0;
                end
            end
            if (e2 > sx) begin
                sx++;
                err += sx * 2 + 1;
            end
            b.last = (sx > 0) || (beats >= crast_pkg::RUN_CAP);
            done   = b.last;
            pending_pixels.push_back(b);
        end
        if (beats > longest_walk) begin
            longest_walk = beats;
        end
        if (beats >= crast_pkg::RUN_CAP) begin
            capped_walks++;
        end
    endfunction

    function automatic t_circle_cmd random_circle();
        t_circle_cmd c;
        c.cx     = 16'($urandom);
        c.cy     = 16'($urandom);
        c.colour = 16'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                c.radius = 5'd0;
            end
            1: begin
                c.radius = 5'(crast_pkg::MAX_RADIUS);
            end
            2: begin
                c.radius = 5'($urandom_range(1, 3));
            end
            default: begin
                c.radius = 5'($urandom_range(0, 31));
            end
        endcase
        // push some circles across the coordinate edges so the mirrors wrap
        if ($urandom_range(0, 7) == 0) begin
            c.cx = 16'(16'hFFFF - $urandom_range(0, 40));
        end
        if ($urandom_range(0, 7) == 0) begin
            c.cy = 16'($urandom_range(0, 40));
        end
        return c;
    endfunction

    // Present one command after an idle gap; return at the edge that takes it.
    // Valid stays high across back-to-back beats (gap 0).
    task automatic send_circle(input t_circle_cmd cmd, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_centre_x <= cmd.cx;
        i_centre_y <= cmd.cy;
        i_radius   <= cmd.radius;
        i_colour   <= cmd.colour;
        do @(posedge i_clk); while (!o_in_ready);
        circles_sent++;
    endtask

    // Hold off the sender until the block has delivered every owed beat.
    task automatic drain_pixels();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        drains++;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Output side: drive ready with random stalls, mostly short, a few long,
    // and now and then a long stretch with no stall at all.
    initial begin : out_stalls
        int ready_len;
        int stall_len;
        bit calm;
        forever begin
            calm      = ($urandom_range(0, 5) == 0);
            ready_len = calm ? $urandom_range(80, 200) : $urandom_range(1, 8);
            i_out_ready <= 1'b1;
            repeat (ready_len) @(posedge i_clk);
            if (!calm) begin
                stall_len = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 40)
                                                         : $urandom_range(1, 3);
                i_out_ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    // Compare every accepted beat against the oldest owed beat.
    always @(posedge i_clk) begin
        t_pixel_beat want;
        if (i_rst_n && o_out_valid && !i_out_ready) begin
            stall_cycles++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen++;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t ns: unexpected beat, expected none, actual lt=(%h,%h) last=%b",
                         $time, o_left_top_x, o_left_top_y, o_last);
            end else begin
                want = pending_pixels.pop_front();
                check_field("left_top_x",     want.lt_x,   o_left_top_x);
                check_field("left_top_y",     want.lt_y,   o_left_top_y);
                check_field("left_bottom_x",  want.lb_x,   o_left_bottom_x);
                check_field("left_bottom_y",  want.lb_y,   o_left_bottom_y);
                check_field("right_top_x",    want.rt_x,   o_right_top_x);
                check_field("right_top_y",    want.rt_y,   o_right_top_y);
                check_field("right_bottom_x", want.rb_x,   o_right_bottom_x);
                check_field("right_bottom_y", want.rb_y,   o_right_bottom_y);
                check_field("pixel_colour",   want.colour, o_pixel_colour);
                check_field("last",           16'(want.last), 16'(o_last));
            end
        end
    end

    // Main sequence: reset, directed table, random circles, drain, verdict.
    initial begin : stimulus
        int          gap;
        bit          burst;
        t_circle_cmd cmd;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the table; alternate back-to-back beats with short gaps.
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            send_circle(directed_rows[row].cmd, (row % 3 == 0) ? 0 : row % 4);
            if (directed_rows[row].typed) begin
                pending_pixels.push_back(directed_rows[row].beat);
                if (longest_walk < 1) begin
                    longest_walk = 1;
                end
            end else begin
                trace_circle(directed_rows[row].cmd);
            end
        end

        // Let the block go fully idle before the random part.
        drain_pixels();

        // Random circles in bursts: some bursts with no sender gaps at all,
        // the rest with mostly short and a few long gaps.
        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BURST_LEN == 0) begin
                burst = ($urandom_range(0, 2) == 0);
            end
            if (burst) begin
                gap = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                gap = $urandom_range(8, 60);
            end else begin
                gap = $urandom_range(0, 2);
            end
            cmd = random_circle();
            send_circle(cmd, gap);
            trace_circle(cmd);
            if ($urandom_range(0, 39) == 0) begin
                drain_pixels();
            end
        end

        // Drop valid, collect the tail, then watch for stray beats.
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (2 * crast_pkg::RUN_CAP) @(posedge i_clk);

        $display("Drew %0d circles as %0d pixel beats; longest walk %0d beats, %0d hit the cap.",
                 circles_sent, beats_seen, longest_walk, capped_walks);
        $display("Radii 0..31 with wrapping centres; %0d stalled output cycles, %0d full drains.",
                 stall_cycles, drains);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #25_000_000;
        $display("Timeout with %0d beats still owed", pending_pixels.size());
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
